@@ hw/rtl/hmlp_pkg.sv @@
// Shared types and constants for the linear-probing hash map.
// Holds the request and result beat structs, operation and slot mark codes,
// and the hash mixing constants. Depends on nothing.
package hmlp_pkg;

	localparam int unsigned CNT_W = 11;
	localparam int unsigned MIX_SHIFT = 33;
	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [63:0] key;
		logic signed [63:0] value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [63:0] read_value;
		logic               status;
		logic [CNT_W-1:0]   live_count;
	} rsp_t;

	typedef struct packed {
		logic mark;
		logic key;
		logic value;
	} tbl_wen_t;

endpackage

@@ hw/rtl/hmlp_hash.sv @@
// Iterative 64-bit finalizer hash built around one shared 32x32 multiplier.
// Each product is summed from 32x32 partial products. Depends on hmlp_pkg.
module hmlp_hash import hmlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [63:0] hash
);

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_MUL,
		HS_MIX
	} hs_state_t;

	hs_state_t   state_q;
	logic [1:0]  step_q;
	logic        round_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;

	logic [63:0] mult_c;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	always_comb begin
		mult_c = round_q ? MIX_C2 : MIX_C1;
		op_a = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
		op_b = (step_q == 2'd2) ? mult_c[63:32] : mult_c[31:0];
		prod = {32'd0, op_a} * {32'd0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			step_q <= 2'd0;
			round_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				HS_IDLE: begin
					if (start) begin
						a_q <= key ^ (key >> MIX_SHIFT);
						step_q <= 2'd0;
						round_q <= 1'b0;
						state_q <= HS_MUL;
					end
				end
				HS_MUL: begin
					unique case (step_q)
						2'd0: begin
							acc_q <= prod;
							step_q <= 2'd1;
						end
						2'd1: begin
							acc_q <= acc_q + {prod[31:0], 32'd0};
							step_q <= 2'd2;
						end
						default: begin
							acc_q <= acc_q + {prod[31:0], 32'd0};
							step_q <= 2'd0;
							state_q <= HS_MIX;
						end
					endcase
				end
				HS_MIX: begin
					a_q <= acc_q ^ (acc_q >> MIX_SHIFT);
					if (!round_q) begin
						round_q <= 1'b1;
						state_q <= HS_MUL;
					end else begin
						done_q <= 1'b1;
						state_q <= HS_IDLE;
					end
				end
				default: state_q <= HS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign hash = a_q;

endmodule

@@ hw/rtl/hmlp_table.sv @@
// Slot store of the hash map: marks, keys and values at one shared address,
// one registered read and one write per cycle. Depends on hmlp_pkg.
module hmlp_table import hmlp_pkg::*; #(
	parameter int unsigned CAPACITY = 1024,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic        clk,
	input  logic [AW-1:0] rd_addr,
	output mark_t       rd_mark,
	output logic [63:0] rd_key,
	output logic [63:0] rd_value,
	input  tbl_wen_t    wr_en,
	input  logic [AW-1:0] wr_addr,
	input  mark_t       wr_mark,
	input  logic [63:0] wr_key,
	input  logic [63:0] wr_value
);

	mark_t       marks_mem [CAPACITY];
	logic [63:0] keys_mem [CAPACITY];
	logic [63:0] values_mem [CAPACITY];

	mark_t       rd_mark_q;
	logic [63:0] rd_key_q;
	logic [63:0] rd_value_q;

	always_ff @(posedge clk) begin
		if (wr_en.mark) begin
			marks_mem[wr_addr] <= wr_mark;
		end
		if (wr_en.key) begin
			keys_mem[wr_addr] <= wr_key;
		end
		if (wr_en.value) begin
			values_mem[wr_addr] <= wr_value;
		end
		rd_mark_q <= marks_mem[rd_addr];
		rd_key_q <= keys_mem[rd_addr];
		rd_value_q <= values_mem[rd_addr];
	end

	assign rd_mark = rd_mark_q;
	assign rd_key = rd_key_q;
	assign rd_value = rd_value_q;

endmodule

@@ hw/rtl/hash_map_linear_probe.sv @@
// Linear-probing hash map from 64-bit keys to 64-bit values.
// Uses hmlp_pkg, hmlp_hash and hmlp_table.
//
// A request beat (lookup, insert-or-update or remove) is taken on a rising
// edge with start high and busy low. The block then stays busy while it
// hashes the key and walks the table. Exactly one result beat follows,
// shown on result for a single cycle with done high; the receiver cannot
// stall it, and busy is already low in that cycle.
// The key is hashed on one shared 32x32 multiplier, the home slot is then
// read, and the probe checks one slot per cycle through the single read
// port of the slot store, visiting 1 to CAPACITY slots.
// After reset the marks are cleared to empty, one slot a cycle, and busy
// stays high until every slot is cleared; max_entries may be written meanwhile.
// max_entries is written by cfg_wr_en and cfg_wr_data and resets to 512.
// CAPACITY must be a power of two; the home slot is the hash masked.
module hash_map_linear_probe import hmlp_pkg::*; #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             request,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data
);

	localparam int unsigned AW = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    cur_q;
	logic [AW-1:0]    n_q;
	logic [AW-1:0]    tomb_q;
	logic             tomb_seen_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] max_q;
	logic             done_q;
	rsp_t             result_q;
	req_t             req_q;

	logic             hash_start;
	logic             hash_done;
	logic [63:0]      hash;

	mark_t            rd_mark;
	logic [63:0]      rd_key;
	logic [63:0]      rd_value;
	logic [AW-1:0]    rd_addr;
	tbl_wen_t         wr_en;
	logic [AW-1:0]    wr_addr;
	mark_t            wr_mark;

	logic             probe_hit;
	logic             probe_empty;
	logic             probe_tomb;
	logic             probe_stop;
	logic             free_ok;
	logic [AW-1:0]    free_addr;
	logic [CNT_W-1:0] count_d;
	rsp_t             rsp_d;

	assign hash_start = start && (state_q == ST_IDLE);

	hmlp_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (request.key),
		.done   (hash_done),
		.hash   (hash)
	);

	hmlp_table #(
		.CAPACITY (CAPACITY)
	) u_table (
		.clk      (clk),
		.rd_addr  (rd_addr),
		.rd_mark  (rd_mark),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_mark  (wr_mark),
		.wr_key   (req_q.key),
		.wr_value (req_q.value)
	);

	always_comb begin
		probe_hit = (rd_mark == MARK_LIVE) && (rd_key == req_q.key);
		probe_empty = (rd_mark == MARK_EMPTY);
		probe_tomb = (rd_mark == MARK_TOMB);
		probe_stop = probe_hit || probe_empty || (n_q == {AW{1'b1}});
		free_ok = tomb_seen_q || probe_tomb || probe_empty;
		free_addr = tomb_seen_q ? tomb_q : cur_q;

		wr_en = '0;
		wr_addr = cur_q;
		wr_mark = MARK_LIVE;
		rd_addr = cur_q + 1'b1;
		count_d = count_q;
		rsp_d = '0;

		unique case (state_q)
			ST_CLEAR: begin
				wr_en.mark = 1'b1;
				wr_addr = clr_q;
				wr_mark = MARK_EMPTY;
			end
			ST_HASH: begin
				rd_addr = hash[AW-1:0];
			end
			ST_PROBE: begin
				if (probe_stop) begin
					unique case (req_q.kind)
						KIND_LOOKUP: begin
							rsp_d.found = probe_hit;
							rsp_d.read_value = probe_hit ? rd_value : 64'sd0;
						end
						KIND_INSERT: begin
							if (probe_hit) begin
								rsp_d.found = 1'b1;
								wr_en.value = 1'b1;
							end else if ((count_q >= max_q) || !free_ok) begin
								rsp_d.status = 1'b1;
							end else begin
								wr_en = '{mark: 1'b1, key: 1'b1, value: 1'b1};
								wr_addr = free_addr;
								count_d = count_q + 1'b1;
							end
						end
						KIND_REMOVE: begin
							if (probe_hit) begin
								rsp_d.found = 1'b1;
								wr_en.mark = 1'b1;
								wr_mark = MARK_TOMB;
								if (count_q != '0) begin
									count_d = count_q - 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		rsp_d.live_count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			max_q <= CNT_W'(512);
			done_q <= 1'b0;
			tomb_seen_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						req_q <= request;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						cur_q <= hash[AW-1:0];
						n_q <= '0;
						tomb_seen_q <= 1'b0;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (probe_stop) begin
						count_q <= count_d;
						result_q <= rsp_d;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (probe_tomb && !tomb_seen_q) begin
							tomb_seen_q <= 1'b1;
							tomb_q <= cur_q;
						end
						cur_q <= cur_q + 1'b1;
						n_q <= n_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_PROBE))
		else $error("result beat without a finished probe");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high in the result cycle");

	a_refuse_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> !result.found && (req_q.kind == KIND_INSERT))
		else $error("refusal on a hit or outside an insert");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.read_value != 64'sd0) |-> result.found
			&& (req_q.kind == KIND_LOOKUP))
		else $error("read value returned without a lookup hit");

	a_hash_in_hash_state: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == ST_HASH)
		else $error("hash finished outside the hash phase");

endmodule
